/* hdl/tkd_pkg.sv */
package tkd_pkg;

  localparam int EscapeBufferDefault = 8;

  localparam logic [7:0] BYTE_EOT      = 8'd4;
  localparam logic [7:0] BYTE_BS       = 8'd8;
  localparam logic [7:0] BYTE_TAB      = 8'd9;
  localparam logic [7:0] BYTE_LF       = 8'd10;
  localparam logic [7:0] BYTE_CR       = 8'd13;
  localparam logic [7:0] BYTE_ESC      = 8'd27;
  localparam logic [7:0] BYTE_SPACE    = 8'h20;
  localparam logic [7:0] BYTE_THREE    = 8'h33;
  localparam logic [7:0] BYTE_CAP_A    = 8'h41;
  localparam logic [7:0] BYTE_CAP_B    = 8'h42;
  localparam logic [7:0] BYTE_CAP_C    = 8'h43;
  localparam logic [7:0] BYTE_CAP_D    = 8'h44;
  localparam logic [7:0] BYTE_CAP_F    = 8'h46;
  localparam logic [7:0] BYTE_CAP_H    = 8'h48;
  localparam logic [7:0] BYTE_CAP_O    = 8'h4F;
  localparam logic [7:0] BYTE_CAP_Z    = 8'h5A;
  localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
  localparam logic [7:0] BYTE_SMALL_A  = 8'h61;
  localparam logic [7:0] BYTE_SMALL_Z  = 8'h7A;
  localparam logic [7:0] BYTE_TILDE    = 8'h7E;
  localparam logic [7:0] BYTE_DEL      = 8'h7F;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_CHAR   = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    EV_END       = 4'd0,
    EV_ENTER     = 4'd1,
    EV_BACKSPACE = 4'd2,
    EV_TAB       = 4'd3,
    EV_UP        = 4'd4,
    EV_DOWN      = 4'd5,
    EV_RIGHT     = 4'd6,
    EV_LEFT      = 4'd7,
    EV_DELETE    = 4'd8,
    EV_HOME      = 4'd9,
    EV_END_KEY   = 4'd10,
    EV_CHAR      = 4'd11,
    EV_IGNORED   = 4'd12
  } key_event_t;

  function automatic logic [2:0] utf8_length(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd1;
    if (b inside {[8'hC0:8'hDF]}) begin
      n = 3'd2;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      n = 3'd3;
    end else if (b inside {[8'hF0:8'hF7]}) begin
      n = 3'd4;
    end
    return n;
  endfunction

endpackage

/* hdl/terminal_key_decoder_top.sv */
// A result is registered and presented in the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle unless a waiting result is not taken; decoding is a single registered pass per byte.
// A waiting result does not block input while the consumer takes it in the same cycle.
// Reset (rst_n low, synchronous) returns the decoder to idle and drops any pending result.
// A partly collected escape sequence or UTF-8 character is discarded by reset.
module terminal_key_decoder_top import tkd_pkg::*; #(
  parameter int ESCAPE_BUFFER = EscapeBufferDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic [0:0]  in_tuser,   // input_closed[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // char_bytes[31:0], char_length[34:32], zero[39:35]
  output logic [3:0]  out_tuser   // key_event[3:0]
);

  localparam int CNT_W = $clog2(ESCAPE_BUFFER);

  mode_t              mode_r, mode_nxt;
  logic [CNT_W-1:0]   esc_cnt_r, esc_cnt_nxt;
  logic [7:0]         esc_first_r, esc_first_nxt;
  logic [7:0]         esc_second_r, esc_second_nxt;
  logic [31:0]        char_buf_r, char_buf_nxt;
  logic [2:0]         char_needed_r, char_needed_nxt;
  logic [1:0]         char_taken_r, char_taken_nxt;

  logic               out_valid_r;
  key_event_t         out_event_r;
  logic [31:0]        out_bytes_r;
  logic [2:0]         out_len_r;

  logic               accept;
  logic [7:0]         b;
  logic               closed;
  logic               ends_seq;
  logic               terminates;
  logic [CNT_W:0]     esc_cnt_inc;
  logic               esc_full;
  key_event_t         seq_event;
  logic [31:0]        char_merged;
  logic [2:0]         char_taken_inc;
  logic               char_done;
  logic [2:0]         lead_len;
  logic               printable;

  logic               emit;
  key_event_t         ev;
  logic [31:0]        ev_bytes;
  logic [2:0]         ev_len;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign closed    = in_tuser[0];

  assign ends_seq   = (b inside {[BYTE_CAP_A:BYTE_CAP_Z], [BYTE_SMALL_A:BYTE_SMALL_Z]}) ||
                      (b == BYTE_TILDE);
  assign terminates = ends_seq && !((esc_cnt_r == '0) && (b == BYTE_CAP_O));
  assign esc_cnt_inc = {1'b0, esc_cnt_r} + (CNT_W+1)'(1);
  assign esc_full    = esc_cnt_inc >= (CNT_W+1)'(ESCAPE_BUFFER - 1);

  always_comb begin
    seq_event = EV_IGNORED;
    if ((esc_cnt_r == CNT_W'(1)) && (esc_first_r == BYTE_LBRACKET)) begin
      case (b)
        BYTE_CAP_A: seq_event = EV_UP;
        BYTE_CAP_B: seq_event = EV_DOWN;
        BYTE_CAP_C: seq_event = EV_RIGHT;
        BYTE_CAP_D: seq_event = EV_LEFT;
        BYTE_CAP_H: seq_event = EV_HOME;
        BYTE_CAP_F: seq_event = EV_END_KEY;
        default:    seq_event = EV_IGNORED;
      endcase
    end else if ((esc_cnt_r == CNT_W'(2)) && (esc_first_r == BYTE_LBRACKET) &&
                 (esc_second_r == BYTE_THREE) && (b == BYTE_TILDE)) begin
      seq_event = EV_DELETE;
    end else if ((esc_cnt_r == CNT_W'(1)) && (esc_first_r == BYTE_CAP_O)) begin
      if (b == BYTE_CAP_H) begin
        seq_event = EV_HOME;
      end else if (b == BYTE_CAP_F) begin
        seq_event = EV_END_KEY;
      end
    end
  end

  assign char_merged    = char_buf_r | ({24'd0, b} << {char_taken_r, 3'b000});
  assign char_taken_inc = {1'b0, char_taken_r} + 3'd1;
  assign char_done      = char_taken_inc >= char_needed_r;
  assign lead_len       = utf8_length(b);
  assign printable      = (b >= BYTE_SPACE) && (b != BYTE_DEL);

  // Next state.
  always_comb begin
    mode_nxt        = mode_r;
    esc_cnt_nxt     = esc_cnt_r;
    esc_first_nxt   = esc_first_r;
    esc_second_nxt  = esc_second_r;
    char_buf_nxt    = char_buf_r;
    char_needed_nxt = char_needed_r;
    char_taken_nxt  = char_taken_r;
    if (accept) begin
      case (mode_r)
        MODE_ESCAPE: begin
          if (closed) begin
            mode_nxt = MODE_IDLE;
          end else begin
            if (esc_cnt_r == '0) begin
              esc_first_nxt = b;
            end
            if (esc_cnt_r == CNT_W'(1)) begin
              esc_second_nxt = b;
            end
            if (terminates) begin
              mode_nxt = MODE_IDLE;
            end else begin
              esc_cnt_nxt = esc_cnt_inc[CNT_W-1:0];
              if (esc_full) begin
                mode_nxt = MODE_IDLE;
              end
            end
          end
        end
        MODE_CHAR: begin
          if (closed) begin
            mode_nxt = MODE_IDLE;
          end else begin
            char_buf_nxt   = char_merged;
            char_taken_nxt = char_taken_inc[1:0];
            if (char_done) begin
              mode_nxt = MODE_IDLE;
            end
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
          if (!closed && (b == BYTE_ESC)) begin
            mode_nxt       = MODE_ESCAPE;
            esc_cnt_nxt    = '0;
            esc_first_nxt  = '0;
            esc_second_nxt = '0;
          end else if (!closed && printable) begin
            char_buf_nxt    = {24'd0, b};
            char_needed_nxt = lead_len;
            char_taken_nxt  = 2'd1;
            if (lead_len > 3'd1) begin
              mode_nxt = MODE_CHAR;
            end
          end
        end
      endcase
    end
  end

  // Result of the current request.
  always_comb begin
    emit     = 1'b0;
    ev       = EV_IGNORED;
    ev_bytes = '0;
    ev_len   = '0;
    case (mode_r)
      MODE_ESCAPE: begin
        if (closed) begin
          emit = 1'b1;
        end else if (terminates) begin
          emit = 1'b1;
          ev   = seq_event;
        end else if (esc_full) begin
          emit = 1'b1;
        end
      end
      MODE_CHAR: begin
        if (closed) begin
          emit = 1'b1;
          ev   = EV_END;
        end else if (char_done) begin
          emit     = 1'b1;
          ev       = EV_CHAR;
          ev_bytes = char_merged;
          ev_len   = char_needed_r;
        end
      end
      default: begin
        if (closed || (b == BYTE_EOT)) begin
          emit = 1'b1;
          ev   = EV_END;
        end else if (b == BYTE_ESC) begin
          emit = 1'b0;
        end else if (b inside {BYTE_LF, BYTE_CR}) begin
          emit = 1'b1;
          ev   = EV_ENTER;
        end else if (b inside {BYTE_DEL, BYTE_BS}) begin
          emit = 1'b1;
          ev   = EV_BACKSPACE;
        end else if (b == BYTE_TAB) begin
          emit = 1'b1;
          ev   = EV_TAB;
        end else if (printable) begin
          if (lead_len <= 3'd1) begin
            emit     = 1'b1;
            ev       = EV_CHAR;
            ev_bytes = {24'd0, b};
            ev_len   = 3'd1;
          end
        end else begin
          emit = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      esc_cnt_r     <= '0;
      esc_first_r   <= '0;
      esc_second_r  <= '0;
      char_buf_r    <= '0;
      char_needed_r <= '0;
      char_taken_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      mode_r        <= mode_nxt;
      esc_cnt_r     <= esc_cnt_nxt;
      esc_first_r   <= esc_first_nxt;
      esc_second_r  <= esc_second_nxt;
      char_buf_r    <= char_buf_nxt;
      char_needed_r <= char_needed_nxt;
      char_taken_r  <= char_taken_nxt;
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_event_r <= ev;
      out_bytes_r <= ev_bytes;
      out_len_r   <= ev_len;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_event_r;
  assign out_tdata  = {5'd0, out_len_r, out_bytes_r};

  a_char_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_event_r == EV_CHAR) |-> (out_len_r >= 3'd1) && (out_len_r <= 3'd4))
    else $error("character result with a bad length");

  a_non_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_event_r != EV_CHAR) |-> (out_bytes_r == '0) && (out_len_r == '0))
    else $error("non-character result carries character bytes");

  a_char_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_CHAR) |-> ({1'b0, char_taken_r} < char_needed_r))
    else $error("character collection overran its length");

  a_escape_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ESCAPE) |-> ({1'b0, esc_cnt_r} < (CNT_W+1)'(ESCAPE_BUFFER - 1)))
    else $error("escape sequence overran its buffer");

  a_closed_idle_end: assert property (@(posedge clk) disable iff (!rst_n)
    accept && closed && (mode_r == MODE_IDLE) |=> out_valid_r && (out_event_r == EV_END))
    else $error("closed input in idle did not give end");

endmodule

/* verif/tkd_key_checker.sv */
`timescale 1ns / 1ps

module tkd_key_checker import tkd_pkg::*; #(
  parameter int ESCAPE_BUFFER = EscapeBufferDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [3:0]  out_tuser,
  output int          fail_count,
  output int          awaited,
  output int          keys_checked,
  output logic [12:0] kinds_seen
);

  typedef struct packed {
    key_event_t  kind;
    logic [31:0] glyph;
    logic [2:0]  glyph_len;
  } key_report_t;

  key_report_t awaited_keys[$];

  mode_t       seq_mode;
  int          seq_taken;
  logic [7:0]  seq_first;
  logic [7:0]  seq_second;
  logic [31:0] glyph_bytes;
  int          glyph_need;
  int          glyph_have;

  initial begin
    fail_count   = 0;
    awaited      = 0;
    keys_checked = 0;
    kinds_seen   = '0;
  end

  function automatic bit is_terminator(input logic [7:0] b);
    return (b >= BYTE_CAP_A && b <= BYTE_CAP_Z) || (b >= BYTE_SMALL_A && b <= BYTE_SMALL_Z) ||
           b == BYTE_TILDE;
  endfunction

  function automatic int glyph_length(input logic [7:0] b);
    if (b >= 8'hC0 && b <= 8'hDF) begin
      return 2;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      return 3;
    end else if (b >= 8'hF0 && b <= 8'hF7) begin
      return 4;
    end
    return 1;
  endfunction

  function automatic key_event_t sequence_key(input int n, input logic [7:0] first,
                                              input logic [7:0] second, input logic [7:0] last);
    if (n == 2 && first == BYTE_LBRACKET) begin
      case (last)
        BYTE_CAP_A: return EV_UP;
        BYTE_CAP_B: return EV_DOWN;
        BYTE_CAP_C: return EV_RIGHT;
        BYTE_CAP_D: return EV_LEFT;
        BYTE_CAP_H: return EV_HOME;
        BYTE_CAP_F: return EV_END_KEY;
        default: return EV_IGNORED;
      endcase
    end
    if (n == 3 && first == BYTE_LBRACKET && second == BYTE_THREE && last == BYTE_TILDE) begin
      return EV_DELETE;
    end
    if (n == 2 && first == BYTE_CAP_O) begin
      if (last == BYTE_CAP_H) begin
        return EV_HOME;
      end
      if (last == BYTE_CAP_F) begin
        return EV_END_KEY;
      end
    end
    return EV_IGNORED;
  endfunction

  task automatic decode_key_byte(input logic [7:0] b, input bit closed, output bit emits,
                                 output key_report_t key);
    key = '{kind: EV_IGNORED, glyph: '0, glyph_len: '0};
    emits = 1'b1;
    case (seq_mode)
      MODE_ESCAPE: begin
        if (closed) begin
          seq_mode = MODE_IDLE;
        end else begin
          if (seq_taken == 0) begin
            seq_first = b;
          end else if (seq_taken == 1) begin
            seq_second = b;
          end
          if (is_terminator(b) && !(seq_taken == 0 && b == BYTE_CAP_O)) begin
            seq_mode = MODE_IDLE;
            key.kind = sequence_key(seq_taken + 1, seq_first, seq_second, b);
          end else begin
            seq_taken++;
            if (seq_taken >= ESCAPE_BUFFER - 1) begin
              seq_mode = MODE_IDLE;
            end else begin
              emits = 1'b0;
            end
          end
        end
      end
      MODE_CHAR: begin
        if (closed) begin
          seq_mode = MODE_IDLE;
          key.kind = EV_END;
        end else begin
          if (glyph_have < 4) begin
            glyph_bytes |= 32'(b) << (8 * glyph_have);
          end
          glyph_have++;
          if (glyph_have >= glyph_need) begin
            seq_mode      = MODE_IDLE;
            key.kind      = EV_CHAR;
            key.glyph     = glyph_bytes;
            key.glyph_len = 3'(glyph_need);
          end else begin
            emits = 1'b0;
          end
        end
      end
      default: begin
        seq_mode = MODE_IDLE;
        if (closed || b == BYTE_EOT) begin
          key.kind = EV_END;
        end else if (b == BYTE_ESC) begin
          seq_mode   = MODE_ESCAPE;
          seq_taken  = 0;
          seq_first  = '0;
          seq_second = '0;
          emits      = 1'b0;
        end else if (b == BYTE_LF || b == BYTE_CR) begin
          key.kind = EV_ENTER;
        end else if (b == BYTE_DEL || b == BYTE_BS) begin
          key.kind = EV_BACKSPACE;
        end else if (b == BYTE_TAB) begin
          key.kind = EV_TAB;
        end else if (b >= BYTE_SPACE) begin
          glyph_bytes = 32'(b);
          glyph_need  = glyph_length(b);
          glyph_have  = 1;
          if (glyph_need <= 1) begin
            key.kind      = EV_CHAR;
            key.glyph     = 32'(b);
            key.glyph_len = 3'd1;
          end else begin
            seq_mode = MODE_CHAR;
            emits    = 1'b0;
          end
        end
      end
    endcase
  endtask

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    key_report_t want;
    key_report_t got;
    bit          emits;
    if (!rst_n) begin
      seq_mode    = MODE_IDLE;
      seq_taken   = 0;
      seq_first   = '0;
      seq_second  = '0;
      glyph_bytes = '0;
      glyph_need  = 0;
      glyph_have  = 0;
      awaited_keys.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.kind      = key_event_t'(out_tuser);
        got.glyph     = out_tdata[31:0];
        got.glyph_len = out_tdata[34:32];
        keys_checked++;
        if (awaited_keys.size() == 0) begin
          flag_mismatch($sformatf("key %0d arrived with no request waiting", out_tuser));
        end else begin
          want = awaited_keys.pop_front();
          kinds_seen[want.kind] = 1'b1;
          if (got.kind != want.kind) begin
            flag_mismatch($sformatf("key_event %0d, wanted %s", out_tuser, want.kind.name()));
          end
          if (got.glyph != want.glyph) begin
            flag_mismatch($sformatf("char_bytes %h, wanted %h", got.glyph, want.glyph));
          end
          if (got.glyph_len != want.glyph_len) begin
            flag_mismatch($sformatf("char_length %0d, wanted %0d", got.glyph_len, want.glyph_len));
          end
          if (out_tdata[39:35] != '0) begin
            flag_mismatch($sformatf("padding bits %b are not zero", out_tdata[39:35]));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        decode_key_byte(in_tdata, in_tuser[0], emits, want);
        if (emits) begin
          awaited_keys.push_back(want);
        end
      end
    end
    awaited = awaited_keys.size();
  end

endmodule

/* verif/tb_terminal_key_decoder_top.sv */
`timescale 1ns / 1ps

module tb_terminal_key_decoder_top import tkd_pkg::*;;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [3:0]  out_tuser;

  int          fail_count;
  int          awaited;
  int          keys_checked;
  logic [12:0] kinds_seen;
  int          bytes_sent;
  bit          in_steady;
  bit          out_steady;

  terminal_key_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  tkd_key_checker u_key_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .awaited      (awaited),
    .keys_checked (keys_checked),
    .kinds_seen   (kinds_seen)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #10 clk = ~clk;
    end
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    in_steady  = 1'b0;
    out_steady = 1'b0;
    forever begin
      repeat ($urandom_range(40, 400)) @(posedge clk);
      in_steady  = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : key_sink
    int gap;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      gap = out_steady ? 0 : $urandom_range(0, 17);
      while (gap > 0) begin
        out_tready <= 1'b0;
        gap--;
        @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic push_byte(input logic [7:0] b, input bit closed);
    int gap;
    @(negedge clk);
    gap = in_steady ? 0 : $urandom_range(0, 17);
    while (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tuser  <= 1'($urandom);
      gap--;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= closed ? 8'($urandom) : b;
    in_tuser  <= closed;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    bytes_sent++;
  endtask

  // Any byte after the first may be cut short by a closed input.
  task automatic play_run(input logic [7:0] run[$]);
    foreach (run[i]) begin
      if (i > 0 && $urandom_range(0, 11) == 0) begin
        push_byte(8'h00, 1'b1);
        return;
      end
      push_byte(run[i], 1'b0);
    end
  endtask

  function automatic logic [7:0] escape_filler();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(8'h30, 8'h39));
      1: return 8'h3B;
      2: return 8'($urandom_range(8'h80, 8'hFF));
      3: return BYTE_LBRACKET;
      4: return BYTE_CAP_O;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_item();
    logic [7:0] run[$];
    int         pick;
    int         n;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      run.push_back(8'($urandom_range(0, 31)));
    end else if (pick < 24) begin
      run.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end else if (pick < 44) begin
      n = $urandom_range(2, 4);
      case (n)
        2: run.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        3: run.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        default: run.push_back(8'($urandom_range(8'hF0, 8'hF7)));
      endcase
      repeat (n - 1) begin
        if ($urandom_range(0, 4) == 0) begin
          run.push_back(8'($urandom));
        end else begin
          run.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
      end
    end else if (pick < 64) begin
      run.push_back(BYTE_ESC);
      n = $urandom_range(0, 8);
      if (n == 6 || n == 7) begin
        run.push_back(BYTE_CAP_O);
        run.push_back(n == 6 ? BYTE_CAP_H : BYTE_CAP_F);
      end else begin
        run.push_back(BYTE_LBRACKET);
        case (n)
          0: run.push_back(BYTE_CAP_A);
          1: run.push_back(BYTE_CAP_B);
          2: run.push_back(BYTE_CAP_C);
          3: run.push_back(BYTE_CAP_D);
          4: run.push_back(BYTE_CAP_H);
          5: run.push_back(BYTE_CAP_F);
          default: begin
            run.push_back(BYTE_THREE);
            run.push_back(BYTE_TILDE);
          end
        endcase
      end
    end else if (pick < 78) begin
      run.push_back(BYTE_ESC);
      repeat ($urandom_range(0, 8)) run.push_back(escape_filler());
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 2))
          0: run.push_back(8'($urandom_range(BYTE_CAP_A, BYTE_CAP_Z)));
          1: run.push_back(8'($urandom_range(BYTE_SMALL_A, BYTE_SMALL_Z)));
          default: run.push_back(BYTE_TILDE);
        endcase
      end
    end else if (pick < 84) begin
      push_byte(8'h00, 1'b1);
      return;
    end else if (pick < 90) begin
      if ($urandom_range(0, 1) == 0) begin
        run.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else begin
        run.push_back(8'($urandom_range(8'hF8, 8'hFF)));
      end
    end else begin
      run.push_back(8'($urandom));
    end
    play_run(run);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    bytes_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_byte(BYTE_EOT, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(BYTE_CR, 1'b0);
    push_byte(BYTE_LF, 1'b0);
    push_byte(BYTE_DEL, 1'b0);
    push_byte(BYTE_BS, 1'b0);
    push_byte(BYTE_TAB, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h1F, 1'b0);
    push_byte(BYTE_ESC, 1'b0);
    push_byte(BYTE_LBRACKET, 1'b0);
    push_byte(BYTE_CAP_A, 1'b0);
    push_byte(BYTE_ESC, 1'b0);
    push_byte(BYTE_CAP_O, 1'b0);
    push_byte(BYTE_CAP_H, 1'b0);
    push_byte(BYTE_ESC, 1'b0);
    push_byte(BYTE_LBRACKET, 1'b0);
    push_byte(BYTE_THREE, 1'b0);
    push_byte(BYTE_TILDE, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h9F, 1'b0);
    push_byte(8'h98, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);

    while (bytes_sent < 425) begin
      random_item();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited != 0) begin
      @(negedge clk);
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes of controls, characters, escape sequences and closed input.",
             bytes_sent);
    $display("Checked %0d keys; %0d of 13 key kinds were seen.", keys_checked,
             $countones(kinds_seen));
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
